[src/sfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the serial frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [2:0] PH_PREAMBLE = 3'd0;
  localparam logic [2:0] PH_HEADER   = 3'd1;
  localparam logic [2:0] PH_DATA     = 3'd2;
  localparam logic [2:0] PH_TRAILER  = 3'd3;
  localparam logic [2:0] PH_HUNT     = 3'd4;

  localparam logic [2:0] KIND_DATA         = 3'd0;
  localparam logic [2:0] KIND_ACCEPT       = 3'd1;
  localparam logic [2:0] KIND_TRAILER_BAD  = 3'd2;
  localparam logic [2:0] KIND_PREAMBLE_BAD = 3'd3;
  localparam logic [2:0] KIND_SYNC         = 3'd4;

  localparam logic [7:0] CH_M  = 8'h4D;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  position;
    logic        hunt_seen_m;
    logic        hunt_seen_s;
    logic [7:0]  held_msg_id;
    logic [7:0]  held_transaction;
    logic [15:0] held_crc;
    logic [7:0]  held_length;
    logic        trailer_mismatch;
  } state_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  msg_id;
    logic [7:0]  transaction_id;
    logic [15:0] crc_value;
    logic [7:0]  payload_length;
  } result_t;

endpackage

[src/sfd_rx_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_rx_if / sfd_res_if
// Valid/ready channels for received bytes and deframer results.
// ----------------------------------------------------------------------------
interface sfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic [7:0]  msg_id;
  logic [7:0]  transaction_id;
  logic [15:0] crc_value;
  logic [7:0]  payload_length;

  modport source (output valid, output out_kind, output data_byte, output byte_index,
                  output msg_id, output transaction_id, output crc_value,
                  output payload_length, input ready);
  modport sink   (input valid, input out_kind, input data_byte, input byte_index,
                  input msg_id, input transaction_id, input crc_value,
                  input payload_length, output ready);
endinterface

[src/serial_frame_deframer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_deframer_core
// Splits a received byte stream into MSG/header/payload/END frames and
// reports payload bytes, frame verdicts and resynchronization.
// ----------------------------------------------------------------------------
// channel  dir  payload
// rx       in   rx_byte
// res      out  out_kind, data_byte, byte_index, msg_id, transaction_id,
//               crc_value, payload_length (zero or one transfer per byte)
//
// One byte per cycle while res does not stall; the frame state updates in the cycle the byte transfers
// and its result appears on res the next cycle from the output register.
// rx is ready whenever the output register is empty or is emptied that cycle.
// A stall on res holds one result and blocks rx only while it is held.
// Synchronous reset returns to preamble matching with cleared header fields.
// ----------------------------------------------------------------------------
module serial_frame_deframer_core (
  input  logic             clk,
  input  logic             rst,
  sfd_rx_if.sink           rx,
  sfd_res_if.source        res
);

  sfd_pkg::state_t  st;
  sfd_pkg::state_t  st_next;
  sfd_pkg::result_t step_res;
  sfd_pkg::result_t out_reg;
  logic             step_valid;
  logic             out_valid;
  logic             take;

  sfd_step u_step (
    .cur       (st),
    .rx_byte   (rx.rx_byte),
    .nxt       (st_next),
    .res_valid (step_valid),
    .res       (step_res)
  );

  assign rx.ready = !out_valid || res.ready;
  assign take     = rx.valid && rx.ready;

  // all-zero state is preamble matching at position zero
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        st <= st_next;
      end
      if (take) begin
        out_valid <= step_valid;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && step_valid) begin
      out_reg <= step_res;
    end
  end

  assign res.valid          = out_valid;
  assign res.out_kind       = out_reg.out_kind;
  assign res.data_byte      = out_reg.data_byte;
  assign res.byte_index     = out_reg.byte_index;
  assign res.msg_id         = out_reg.msg_id;
  assign res.transaction_id = out_reg.transaction_id;
  assign res.crc_value      = out_reg.crc_value;
  assign res.payload_length = out_reg.payload_length;

endmodule

[src/sfd_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_step
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
module sfd_step (
  input  sfd_pkg::state_t  cur,
  input  logic [7:0]       rx_byte,
  output sfd_pkg::state_t  nxt,
  output logic             res_valid,
  output sfd_pkg::result_t res
);

  logic [7:0] pre_char;
  logic [7:0] trl_char;
  logic [8:0] idx_inc;
  logic       trl_bad;

  always_comb begin
    unique case (cur.position[1:0])
      2'd0:    pre_char = sfd_pkg::CH_M;
      2'd1:    pre_char = sfd_pkg::CH_S;
      default: pre_char = sfd_pkg::CH_G;
    endcase
    unique case (cur.position[1:0])
      2'd0:    trl_char = sfd_pkg::CH_E;
      2'd1:    trl_char = sfd_pkg::CH_N;
      2'd2:    trl_char = sfd_pkg::CH_D;
      default: trl_char = sfd_pkg::CH_LF;
    endcase
  end

  assign idx_inc = {1'b0, cur.position} + 9'd1;
  assign trl_bad = cur.trailer_mismatch | (rx_byte != trl_char);

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    unique case (cur.phase)
      sfd_pkg::PH_PREAMBLE: begin
        if (rx_byte != pre_char) begin
          nxt.hunt_seen_m      = 1'b0;
          nxt.hunt_seen_s      = 1'b0;
          nxt.phase            = sfd_pkg::PH_HUNT;
          nxt.position         = '0;
          nxt.trailer_mismatch = 1'b0;
          res_valid            = 1'b1;
          res.out_kind         = sfd_pkg::KIND_PREAMBLE_BAD;
        end else if (cur.position >= 8'd2) begin
          nxt.phase            = sfd_pkg::PH_HEADER;
          nxt.position         = '0;
          nxt.trailer_mismatch = 1'b0;
        end else begin
          nxt.position = idx_inc[7:0];
        end
      end
      sfd_pkg::PH_HEADER: begin
        unique case (cur.position)
          8'd0:    nxt.held_msg_id      = rx_byte;
          8'd1:    nxt.held_transaction = rx_byte;
          8'd2:    nxt.held_crc[7:0]    = rx_byte;
          8'd3:    nxt.held_crc[15:8]   = rx_byte;
          default: nxt.held_length      = rx_byte;
        endcase
        if (cur.position >= 8'd4) begin
          nxt.phase = (rx_byte == 8'd0) ? sfd_pkg::PH_TRAILER : sfd_pkg::PH_DATA;
          nxt.position         = '0;
          nxt.trailer_mismatch = 1'b0;
        end else begin
          nxt.position = idx_inc[7:0];
        end
      end
      sfd_pkg::PH_DATA: begin
        res_valid      = 1'b1;
        res.out_kind   = sfd_pkg::KIND_DATA;
        res.data_byte  = rx_byte;
        res.byte_index = cur.position;
        if (idx_inc >= {1'b0, cur.held_length}) begin
          nxt.phase            = sfd_pkg::PH_TRAILER;
          nxt.position         = '0;
          nxt.trailer_mismatch = 1'b0;
        end else begin
          nxt.position = idx_inc[7:0];
        end
      end
      sfd_pkg::PH_TRAILER: begin
        if (cur.position < 8'd3) begin
          nxt.trailer_mismatch = trl_bad;
          nxt.position         = idx_inc[7:0];
        end else begin
          res_valid            = 1'b1;
          nxt.position         = '0;
          nxt.trailer_mismatch = 1'b0;
          if (trl_bad) begin
            res.out_kind    = sfd_pkg::KIND_TRAILER_BAD;
            nxt.hunt_seen_m = 1'b0;
            nxt.hunt_seen_s = 1'b0;
            nxt.phase       = sfd_pkg::PH_HUNT;
          end else begin
            res.out_kind = sfd_pkg::KIND_ACCEPT;
            nxt.phase    = sfd_pkg::PH_PREAMBLE;
          end
        end
      end
      sfd_pkg::PH_HUNT: begin
        if (!cur.hunt_seen_m) begin
          nxt.hunt_seen_m = (rx_byte == sfd_pkg::CH_M);
        end else if (!cur.hunt_seen_s) begin
          if (rx_byte == sfd_pkg::CH_S) begin
            nxt.hunt_seen_s = 1'b1;
          end else begin
            nxt.hunt_seen_m = 1'b0;
          end
        end else begin
          nxt.hunt_seen_m = 1'b0;
          nxt.hunt_seen_s = 1'b0;
          if (rx_byte == sfd_pkg::CH_G) begin
            nxt.phase            = sfd_pkg::PH_HEADER;
            nxt.position         = '0;
            nxt.trailer_mismatch = 1'b0;
            res_valid            = 1'b1;
            res.out_kind         = sfd_pkg::KIND_SYNC;
          end
        end
      end
      default: begin
        nxt.phase            = sfd_pkg::PH_PREAMBLE;
        nxt.position         = '0;
        nxt.trailer_mismatch = 1'b0;
      end
    endcase
    // header fields ride along with data, accept and trailer-bad results
    if (cur.phase == sfd_pkg::PH_DATA || cur.phase == sfd_pkg::PH_TRAILER) begin
      res.msg_id         = nxt.held_msg_id;
      res.transaction_id = nxt.held_transaction;
      res.crc_value      = nxt.held_crc;
      res.payload_length = nxt.held_length;
    end
  end

endmodule

[dv/tb_serial_frame_deframer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_frame_deframer_core
// Drives received bytes through the deframer and checks every report against
// a cycle-free frame predictor. A short table of directed bytes hits the
// preamble error, non-overlapping hunt, extremes of the header fields, a
// zero-length frame and both trailer verdicts. Random framed traffic follows,
// with corrupted frames and noise, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_serial_frame_deframer_core;

  typedef struct packed {
    logic [7:0]       rx;
    logic             typed;
    logic             with_report;
    sfd_pkg::result_t report;
  } byte_step_t;

  logic clk;
  logic rst;
  bit   quiet = 1'b0;
  int   bytes_sent = 0;
  int   mismatches = 0;

  sfd_rx_if  rx_ch ();
  sfd_res_if res_ch ();

  serial_frame_deframer_core u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  // frame predictor state
  logic [2:0]  fr_phase;
  logic [7:0]  fr_pos;
  logic        fr_seen_m;
  logic        fr_seen_s;
  logic [7:0]  fr_msg_id;
  logic [7:0]  fr_trans;
  logic [15:0] fr_crc;
  logic [7:0]  fr_len;
  logic        fr_trailer_bad;

  // expected reports, ring of 256 entries
  sfd_pkg::result_t expected_reports [0:255];
  int unsigned      exp_wr = 0;
  int unsigned      exp_rd = 0;

  byte_step_t       directed_steps [0:63];
  int unsigned      n_directed = 0;

  logic [7:0]       chunk_bytes [0:511];
  int unsigned      chunk_len = 0;

  function automatic sfd_pkg::result_t report_of(input logic [2:0] kind,
                                                 input logic [7:0] dbyte,
                                                 input logic [7:0] idx,
                                                 input logic [7:0] id,
                                                 input logic [7:0] trans,
                                                 input logic [15:0] crc,
                                                 input logic [7:0] len);
    sfd_pkg::result_t r;
    r.out_kind       = kind;
    r.data_byte      = dbyte;
    r.byte_index     = idx;
    r.msg_id         = id;
    r.transaction_id = trans;
    r.crc_value      = crc;
    r.payload_length = len;
    return r;
  endfunction

  function automatic byte_step_t plain_step(input logic [7:0] b);
    byte_step_t s;
    s = '0;
    s.rx = b;
    return s;
  endfunction

  function automatic byte_step_t typed_step(input logic [7:0] b, input logic has,
                                            input sfd_pkg::result_t r);
    byte_step_t s;
    s.rx          = b;
    s.typed       = 1'b1;
    s.with_report = has;
    s.report      = has ? r : '0;
    return s;
  endfunction

  function automatic void add_step(input byte_step_t s);
    directed_steps[n_directed[5:0]] = s;
    n_directed++;
  endfunction

  function automatic void add_chunk_byte(input logic [7:0] b);
    chunk_bytes[chunk_len[8:0]] = b;
    chunk_len++;
  endfunction

  function automatic void expect_report(input sfd_pkg::result_t r);
    expected_reports[exp_wr[7:0]] = r;
    exp_wr++;
  endfunction

  function automatic void enter_phase(input logic [2:0] p);
    fr_phase       = p;
    fr_pos         = 8'd0;
    fr_trailer_bad = 1'b0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output sfd_pkg::result_t r);
    logic [7:0] want_ch;
    r = '0;
    case (fr_phase)
      sfd_pkg::PH_PREAMBLE: begin
        want_ch = (fr_pos == 8'd0) ? sfd_pkg::CH_M :
                  (fr_pos == 8'd1) ? sfd_pkg::CH_S : sfd_pkg::CH_G;
        if (b != want_ch) begin
          fr_seen_m = 1'b0;
          fr_seen_s = 1'b0;
          enter_phase(sfd_pkg::PH_HUNT);
          r = report_of(sfd_pkg::KIND_PREAMBLE_BAD, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0);
          return 1'b1;
        end
        if (fr_pos >= 8'd2) enter_phase(sfd_pkg::PH_HEADER);
        else fr_pos++;
        return 1'b0;
      end
      sfd_pkg::PH_HEADER: begin
        case (fr_pos)
          8'd0: fr_msg_id = b;
          8'd1: fr_trans = b;
          8'd2: fr_crc[7:0] = b;
          8'd3: fr_crc[15:8] = b;
          default: fr_len = b;
        endcase
        if (fr_pos >= 8'd4)
          enter_phase(fr_len == 8'd0 ? sfd_pkg::PH_TRAILER : sfd_pkg::PH_DATA);
        else fr_pos++;
        return 1'b0;
      end
      sfd_pkg::PH_DATA: begin
        r = report_of(sfd_pkg::KIND_DATA, b, fr_pos, fr_msg_id, fr_trans, fr_crc, fr_len);
        if ({1'b0, fr_pos} + 9'd1 >= {1'b0, fr_len}) enter_phase(sfd_pkg::PH_TRAILER);
        else fr_pos++;
        return 1'b1;
      end
      sfd_pkg::PH_TRAILER: begin
        case (fr_pos[1:0])
          2'd0: want_ch = sfd_pkg::CH_E;
          2'd1: want_ch = sfd_pkg::CH_N;
          2'd2: want_ch = sfd_pkg::CH_D;
          default: want_ch = sfd_pkg::CH_LF;
        endcase
        if (b != want_ch) fr_trailer_bad = 1'b1;
        if (fr_pos < 8'd3) begin
          fr_pos++;
          return 1'b0;
        end
        if (fr_trailer_bad) begin
          r = report_of(sfd_pkg::KIND_TRAILER_BAD, 8'd0, 8'd0, fr_msg_id, fr_trans,
                        fr_crc, fr_len);
          fr_seen_m = 1'b0;
          fr_seen_s = 1'b0;
          enter_phase(sfd_pkg::PH_HUNT);
        end else begin
          r = report_of(sfd_pkg::KIND_ACCEPT, 8'd0, 8'd0, fr_msg_id, fr_trans,
                        fr_crc, fr_len);
          enter_phase(sfd_pkg::PH_PREAMBLE);
        end
        return 1'b1;
      end
      sfd_pkg::PH_HUNT: begin
        if (!fr_seen_m) begin
          if (b == sfd_pkg::CH_M) fr_seen_m = 1'b1;
          return 1'b0;
        end
        if (!fr_seen_s) begin
          if (b == sfd_pkg::CH_S) fr_seen_s = 1'b1;
          else fr_seen_m = 1'b0;
          return 1'b0;
        end
        fr_seen_m = 1'b0;
        fr_seen_s = 1'b0;
        if (b == sfd_pkg::CH_G) begin
          enter_phase(sfd_pkg::PH_HEADER);
          r = report_of(sfd_pkg::KIND_SYNC, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        enter_phase(sfd_pkg::PH_PREAMBLE);
        return 1'b0;
      end
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input byte_step_t s);
    sfd_pkg::result_t predicted;
    bit               produced;
    quiet = (bytes_sent >= 300 && bytes_sent < 450);
    while (!quiet && $urandom_range(99) < 20) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= s.rx;
    do @(posedge clk); while (!rx_ch.ready);
    produced = deframe_byte(s.rx, predicted);
    if (s.typed) begin
      if (s.with_report) expect_report(s.report);
    end else if (produced) begin
      expect_report(predicted);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    do @(negedge clk); while (exp_wr != exp_rd);
  endtask

  task automatic send_random_chunk();
    int unsigned plen;
    int unsigned pos;
    chunk_len = 0;
    if ($urandom_range(99) < 75) begin
      plen = ($urandom_range(39) == 0) ? $urandom_range(255, 100) : $urandom_range(6);
      add_chunk_byte(sfd_pkg::CH_M);
      add_chunk_byte(sfd_pkg::CH_S);
      add_chunk_byte(sfd_pkg::CH_G);
      repeat (4) add_chunk_byte(8'($urandom));
      add_chunk_byte(plen[7:0]);
      repeat (plen) add_chunk_byte(8'($urandom));
      add_chunk_byte(sfd_pkg::CH_E);
      add_chunk_byte(sfd_pkg::CH_N);
      add_chunk_byte(sfd_pkg::CH_D);
      add_chunk_byte(sfd_pkg::CH_LF);
      if ($urandom_range(7) == 0) begin
        pos = $urandom_range(chunk_len - 1);
        chunk_bytes[pos[8:0]] = 8'($urandom);
      end
    end else begin
      repeat ($urandom_range(6, 1)) begin
        case ($urandom_range(5))
          0: add_chunk_byte(sfd_pkg::CH_M);
          1: add_chunk_byte(sfd_pkg::CH_S);
          2: add_chunk_byte(sfd_pkg::CH_G);
          3: add_chunk_byte(sfd_pkg::CH_E);
          default: add_chunk_byte(8'($urandom));
        endcase
      end
    end
    for (int unsigned i = 0; i < chunk_len; i++) send_byte(plain_step(chunk_bytes[i[8:0]]));
  endtask

  task automatic note_mismatch(input string what, input sfd_pkg::result_t want,
                               input sfd_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s", $realtime, what);
      $display("  expected kind=%0d data=%02h idx=%0d id=%02h tr=%02h crc=%04h len=%0d",
               want.out_kind, want.data_byte, want.byte_index, want.msg_id,
               want.transaction_id, want.crc_value, want.payload_length);
      $display("  actual   kind=%0d data=%02h idx=%0d id=%02h tr=%02h crc=%04h len=%0d",
               got.out_kind, got.data_byte, got.byte_index, got.msg_id,
               got.transaction_id, got.crc_value, got.payload_length);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= quiet || ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin : check_reports
    sfd_pkg::result_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = {res_ch.out_kind, res_ch.data_byte, res_ch.byte_index, res_ch.msg_id,
             res_ch.transaction_id, res_ch.crc_value, res_ch.payload_length};
      if (exp_wr == exp_rd) begin
        note_mismatch("unexpected transfer", '0, got);
      end else begin
        if (got !== expected_reports[exp_rd[7:0]])
          note_mismatch("mismatch", expected_reports[exp_rd[7:0]], got);
        exp_rd++;
      end
    end
  end

  initial begin
    bit mid_drain_done;
    mid_drain_done = 1'b0;
    rst            = 1'b1;
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = 8'h00;
    fr_phase       = sfd_pkg::PH_PREAMBLE;
    fr_pos         = 8'd0;
    fr_seen_m      = 1'b0;
    fr_seen_s      = 1'b0;
    fr_msg_id      = 8'd0;
    fr_trans       = 8'd0;
    fr_crc         = 16'd0;
    fr_len         = 8'd0;
    fr_trailer_bad = 1'b0;

    // bad first byte, then "MMSG" must not resync, "MSG" does
    add_step(typed_step(8'h58, 1'b1,
      report_of(sfd_pkg::KIND_PREAMBLE_BAD, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0)));
    add_step(plain_step(sfd_pkg::CH_M));
    add_step(plain_step(sfd_pkg::CH_M));
    add_step(plain_step(sfd_pkg::CH_S));
    add_step(typed_step(sfd_pkg::CH_G, 1'b0, '0));
    add_step(plain_step(sfd_pkg::CH_M));
    add_step(plain_step(sfd_pkg::CH_S));
    add_step(typed_step(sfd_pkg::CH_G, 1'b1,
      report_of(sfd_pkg::KIND_SYNC, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0)));
    // header with field extremes, one payload byte, good trailer
    add_step(plain_step(8'hFF));
    add_step(plain_step(8'h00));
    add_step(plain_step(8'h00));
    add_step(plain_step(8'hFF));
    add_step(plain_step(8'h01));
    add_step(typed_step(8'hFF, 1'b1,
      report_of(sfd_pkg::KIND_DATA, 8'hFF, 8'd0, 8'hFF, 8'h00, 16'hFF00, 8'h01)));
    add_step(plain_step(sfd_pkg::CH_E));
    add_step(plain_step(sfd_pkg::CH_N));
    add_step(plain_step(sfd_pkg::CH_D));
    add_step(typed_step(sfd_pkg::CH_LF, 1'b1,
      report_of(sfd_pkg::KIND_ACCEPT, 8'd0, 8'd0, 8'hFF, 8'h00, 16'hFF00, 8'h01)));
    // zero-length frame with a bad last trailer byte
    add_step(plain_step(sfd_pkg::CH_M));
    add_step(plain_step(sfd_pkg::CH_S));
    add_step(plain_step(sfd_pkg::CH_G));
    add_step(plain_step(8'h00));
    add_step(plain_step(8'hFF));
    add_step(plain_step(8'hFF));
    add_step(plain_step(8'h00));
    add_step(plain_step(8'h00));
    add_step(plain_step(sfd_pkg::CH_E));
    add_step(plain_step(sfd_pkg::CH_N));
    add_step(plain_step(sfd_pkg::CH_D));
    add_step(typed_step(8'hFF, 1'b1,
      report_of(sfd_pkg::KIND_TRAILER_BAD, 8'd0, 8'd0, 8'h00, 8'hFF, 16'h00FF, 8'h00)));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int unsigned i = 0; i < n_directed; i++) send_byte(directed_steps[i[5:0]]);
    wait_drained();

    while (bytes_sent < 800) begin
      if (!mid_drain_done && bytes_sent >= 520) begin
        wait_drained();
        mid_drain_done = 1'b1;
      end
      send_random_chunk();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
src/sfd_pkg.sv
src/sfd_rx_if.sv
src/sfd_step.sv
src/serial_frame_deframer_core.sv
dv/tb_serial_frame_deframer_core.sv
